// ===== hw/rtl/etpe_pkg.sv =====
// Shared types and constants for the echo tap position envelope block.
package etpe_pkg;

   localparam int WIDE_W     = 36;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STEPS  = 31;
   localparam int STEP_CNT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_SPAN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_STEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_MODE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SHAPE = 3'd6;

   localparam logic [1:0] EDGE_CLAMP   = 2'd0;
   localparam logic [1:0] EDGE_REFLECT = 2'd1;
   localparam logic [1:0] EDGE_CYCLE   = 2'd2;

   localparam logic [1:0] SHAPE_FLAT    = 2'd0;
   localparam logic [1:0] SHAPE_LINEAR  = 2'd1;
   localparam logic [1:0] SHAPE_SQUARED = 2'd2;

   localparam logic [1:0] BOUNCE_NONE = 2'd0;
   localparam logic [1:0] BOUNCE_DOWN = 2'd1;
   localparam logic [1:0] BOUNCE_UP   = 2'd2;

   localparam logic [30:0] Q31_ONE = 31'h7FFF_FFFF;

   localparam logic [31:0] RESET_WINDOW_LOW   = 32'd0;
   localparam logic [31:0] RESET_WINDOW_HIGH  = 32'd8388608;
   localparam logic [31:0] RESET_READ_POS     = 32'd4194304;
   localparam logic [30:0] RESET_FADE_SPAN    = 31'd0;
   localparam logic [17:0] RESET_TAP_SPEED    = 18'd256;
   localparam logic [4:0]  RESET_WRITE_STEP   = 5'd1;
   localparam logic [1:0]  RESET_EDGE_MODE    = EDGE_CYCLE;
   localparam logic [1:0]  RESET_WINDOW_SHAPE = SHAPE_FLAT;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic [31:0] window_low;
      logic [31:0] window_high;
      logic [30:0] fade_span;
      logic [17:0] tap_speed;
      logic [4:0]  write_step;
      logic [1:0]  edge_mode;
      logic [1:0]  window_shape;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_EDGE,
      ST_WRAP_SHIFT,
      ST_WRAP_STEP,
      ST_CENTER,
      ST_DIST,
      ST_DIVIDE,
      ST_SCALE,
      ST_CHECK,
      ST_SQUARE,
      ST_SQUARE_DONE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      UOP_HOLD,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_MUL
   } unit_op_type;

   typedef struct packed {
      unit_op_type op;
      logic [31:0] divisor;
      logic [30:0] mul_a;
      logic [30:0] mul_b;
   } unit_req_type;

   typedef struct packed {
      logic [30:0] quotient;
      logic [61:0] product;
   } unit_rsp_type;

endpackage

// ===== hw/rtl/etpe_csr.sv =====
// Configuration register bank with index decode.
module etpe_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [etpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output etpe_pkg::cfg_type             cfg
);
   import etpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LOW:   cfg_in.window_low   = csr_data;
            CSR_WINDOW_HIGH:  cfg_in.window_high  = csr_data;
            CSR_FADE_SPAN:    cfg_in.fade_span    = csr_data[30:0];
            CSR_TAP_SPEED:    cfg_in.tap_speed    = csr_data[17:0];
            CSR_WRITE_STEP:   cfg_in.write_step   = csr_data[4:0];
            CSR_EDGE_MODE:    cfg_in.edge_mode    = csr_data[1:0];
            CSR_WINDOW_SHAPE: cfg_in.window_shape = csr_data[1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_low   <= RESET_WINDOW_LOW;
         cfg_ff.window_high  <= RESET_WINDOW_HIGH;
         cfg_ff.fade_span    <= RESET_FADE_SPAN;
         cfg_ff.tap_speed    <= RESET_TAP_SPEED;
         cfg_ff.write_step   <= RESET_WRITE_STEP;
         cfg_ff.edge_mode    <= RESET_EDGE_MODE;
         cfg_ff.window_shape <= RESET_WINDOW_SHAPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/etpe_unit.sv =====
// Shared arithmetic unit: restoring divide step of Q31 one by a divisor, 31x31 multiply.
module etpe_unit (
   input  logic                   clock,
   input  etpe_pkg::unit_req_type unit_req,
   output etpe_pkg::unit_rsp_type unit_rsp
);
   import etpe_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [30:0] quot_ff, quot_in;
   logic [61:0] prod_ff, prod_in;
   logic [32:0] trial;
   logic [32:0] trial_diff;
   logic        trial_ge;

   // dividend is all ones, so every shifted-in bit is 1
   assign trial      = {rem_ff, 1'b1};
   assign trial_ge   = trial >= {1'b0, unit_req.divisor};
   assign trial_diff = trial - {1'b0, unit_req.divisor};

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      prod_in = prod_ff;
      case (unit_req.op)
         UOP_DIV_INIT: begin
            rem_in  = '0;
            quot_in = '0;
         end
         UOP_DIV_STEP: begin
            rem_in  = trial_ge ? trial_diff[31:0] : trial[31:0];
            quot_in = {quot_ff[29:0], trial_ge};
         end
         UOP_MUL: begin
            prod_in = 62'(unit_req.mul_a) * 62'(unit_req.mul_b);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      prod_ff <= prod_in;
   end

   assign unit_rsp.quotient = quot_ff;
   assign unit_rsp.product  = prod_ff;

endmodule

// ===== hw/rtl/echo_tap_position_envelope_top.sv =====
// Top level of the echo tap position envelope: sequencer, tap state and result register.
//
// Usage:
//   req channel (req_valid / req_stall): one beat per audio tick. req_mode 0 advances the
//   read position by write_step*256 minus the tap speed, applying the edge mode at the
//   window limits; req_mode 1 loads req_new_position and clears the bounce direction.
//   rsp channel (rsp_valid / rsp_stall): one beat per request, carrying the new read
//   position and its Q31 window gain.
//   csr port: csr_write with csr_index / csr_data sets a register at the next clock edge; write
//   only while the block is idle.
// Timing:
//   One request is worked at a time; req_stall is high from acceptance until the
//   sequencer returns to idle. The long path is the gain: one-bit-per-cycle division in
//   the shared unit, plus two passes through its 31x31 multiplier for squared triangle.
//   Flat shape or a degenerate window skips the division and multiply in the unit.
// Reset: synchronous; restores the configuration registers, read position 4194304,
//   no bounce, no response pending.
// Back pressure: the response sits in an output register; a new request is accepted
//   while it waits, but the next response holds in the sequencer until the slot frees.
module echo_tap_position_envelope_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic signed [31:0]             req_new_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_position,
   output logic [30:0]                    rsp_gain,
   input  logic                           csr_write,
   input  logic [etpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import etpe_pkg::*;

   cfg_type      cfg;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   state_type state_ff, state_in;

   // tap state
   logic [31:0] pos_ff, pos_in;
   logic [1:0]  bounce_ff, bounce_in;

   // working registers
   logic signed [19:0]    inc_ff, inc_in;
   wide_type              nt_ff, nt_in;
   wide_type              range_ff, range_in;
   wide_type              wrap_ff, wrap_in;
   wide_type              center_ff, center_in;
   wide_type              half_ff, half_in;
   wide_type              dist_ff, dist_in;
   logic [30:0]           gain_ff, gain_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;
   logic [30:0] rsp_gain_ff, rsp_gain_in;

   logic req_take;
   logic slot_free;

   // widened operands
   wide_type           lo_w, hi_w, t_w;
   logic signed [19:0] spd_raw, spd_mag, spd_eff, step_w, inc_next;
   logic               nt_low, nt_high;
   wide_type           span_raw, wrap_final, diff_c;
   logic               wrap_inside;
   logic               flat_gain;
   logic               zero_gain;

   etpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   etpe_unit u_unit (
      .clock    (clock),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign lo_w = WIDE_W'($signed(cfg.window_low));
   assign hi_w = WIDE_W'($signed(cfg.window_high));
   assign t_w  = WIDE_W'($signed(pos_ff));

   // effective speed after bounce direction
   assign spd_raw = 20'($signed(cfg.tap_speed));
   assign spd_mag = spd_raw[19] ? -spd_raw : spd_raw;
   always_comb begin
      case (bounce_ff)
         BOUNCE_DOWN: spd_eff = -spd_mag;
         BOUNCE_UP:   spd_eff = spd_mag;
         default:     spd_eff = spd_raw;
      endcase
   end
   assign step_w   = 20'($signed(cfg.write_step)) <<< 8;
   assign inc_next = step_w - spd_eff;

   assign nt_low  = nt_ff < lo_w;
   assign nt_high = nt_ff > hi_w;

   assign span_raw    = hi_w - lo_w - $signed(WIDE_W'(cfg.fade_span));
   assign wrap_inside = (wrap_ff <= hi_w) && (wrap_ff >= lo_w);
   assign wrap_final  = wrap_inside ? wrap_ff + WIDE_W'(inc_ff) : wrap_ff;

   assign diff_c = t_w - center_ff;

   assign flat_gain = (cfg.window_shape != SHAPE_LINEAR && cfg.window_shape != SHAPE_SQUARED)
                      || (half_ff <= 0);

   // scaled distance above one, unless the scale factor is zero
   assign zero_gain = (unit_rsp.quotient != '0)
                      && ((|dist_ff[WIDE_W-1:31]) || (|unit_rsp.product[61:31]));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_mode ? ST_CENTER : ST_STEP;
            end
         end
         ST_STEP: state_in = ST_EDGE;
         ST_EDGE: begin
            if (!nt_low && !nt_high) begin
               state_in = ST_CENTER;
            end else if (cfg.edge_mode == EDGE_CLAMP || cfg.edge_mode == EDGE_REFLECT) begin
               state_in = ST_CENTER;
            end else begin
               state_in = ST_WRAP_SHIFT;
            end
         end
         ST_WRAP_SHIFT: state_in = ST_WRAP_STEP;
         ST_WRAP_STEP:  state_in = ST_CENTER;
         ST_CENTER:     state_in = ST_DIST;
         ST_DIST:       state_in = flat_gain ? ST_DONE : ST_DIVIDE;
         ST_DIVIDE: begin
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (zero_gain || cfg.window_shape == SHAPE_LINEAR) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE:      state_in = ST_SQUARE_DONE;
         ST_SQUARE_DONE: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shared unit control
   always_comb begin
      unit_req.op      = UOP_HOLD;
      unit_req.divisor = half_ff[31:0];
      unit_req.mul_a   = dist_ff[30:0];
      unit_req.mul_b   = unit_rsp.quotient;
      case (state_ff)
         ST_DIST:   unit_req.op = UOP_DIV_INIT;
         ST_DIVIDE: unit_req.op = UOP_DIV_STEP;
         ST_SCALE:  unit_req.op = UOP_MUL;
         ST_SQUARE: begin
            unit_req.op    = UOP_MUL;
            unit_req.mul_a = unit_rsp.product[30:0];
            unit_req.mul_b = unit_rsp.product[30:0];
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      pos_in    = pos_ff;
      bounce_in = bounce_ff;
      inc_in    = inc_ff;
      nt_in     = nt_ff;
      range_in  = range_ff;
      wrap_in   = wrap_ff;
      center_in = center_ff;
      half_in   = half_ff;
      dist_in   = dist_ff;
      gain_in   = gain_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_mode) begin
               pos_in    = req_new_position;
               bounce_in = BOUNCE_NONE;
            end
         end
         ST_STEP: begin
            inc_in = inc_next;
            nt_in  = t_w + WIDE_W'(inc_next);
         end
         ST_EDGE: begin
            range_in = span_raw[WIDE_W-1] ? -span_raw : span_raw;
            if (!nt_low && !nt_high) begin
               pos_in = nt_ff[31:0];
            end else if (cfg.edge_mode == EDGE_CLAMP) begin
               pos_in = nt_low ? cfg.window_low : cfg.window_high;
            end else if (cfg.edge_mode == EDGE_REFLECT) begin
               pos_in    = nt_low ? cfg.window_low : cfg.window_high;
               bounce_in = nt_low ? BOUNCE_DOWN : BOUNCE_UP;
            end
         end
         ST_WRAP_SHIFT: begin
            if (nt_high) begin
               wrap_in = t_w - range_ff;
            end else if (nt_low) begin
               wrap_in = t_w + range_ff;
            end else begin
               wrap_in = t_w;
            end
         end
         ST_WRAP_STEP: pos_in = wrap_final[31:0];
         ST_CENTER: begin
            center_in = (lo_w + hi_w + WIDE_W'(1)) >>> 1;
            half_in   = (hi_w - lo_w + WIDE_W'(1)) >>> 1;
         end
         ST_DIST: begin
            dist_in = diff_c[WIDE_W-1] ? -diff_c : diff_c;
            cnt_in  = '0;
            gain_in = Q31_ONE;
         end
         ST_DIVIDE: cnt_in = cnt_ff + STEP_CNT_W'(1);
         ST_CHECK: begin
            if (zero_gain) begin
               gain_in = '0;
            end else begin
               gain_in = Q31_ONE - unit_rsp.product[30:0];
            end
         end
         ST_SQUARE_DONE: gain_in = Q31_ONE - unit_rsp.product[61:31];
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_gain_in  = rsp_gain_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_ff;
         rsp_gain_in  = gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= RESET_READ_POS;
         bounce_ff    <= BOUNCE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bounce_ff    <= bounce_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff      <= inc_in;
      nt_ff       <= nt_in;
      range_ff    <= range_in;
      wrap_ff     <= wrap_in;
      center_ff   <= center_in;
      half_ff     <= half_in;
      dist_ff     <= dist_in;
      gain_ff     <= gain_in;
      cnt_ff      <= cnt_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_gain     = rsp_gain_ff;

endmodule

// ===== verif/tb_echo_tap_position_envelope_top.sv =====
// Self-checking testbench for the echo tap position envelope: random traffic against a predictor.
`timescale 1ns / 100ps

module tb_echo_tap_position_envelope_top;
   import etpe_pkg::*;

   // Quiet cycles (no beat on either channel) before the run is declared hung.
   // The limit must cover a request's work plus random back pressure and the CSR gaps between phases.
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     DRAIN_CYCLES   = 60;
   localparam longint UNITY_GAIN     = longint'(Q31_ONE);
   localparam longint SUBSAMPLES     = 256;
   // Encodings outside the named set; the block treats them as wrap / flat.
   localparam logic [1:0] EDGE_SPARE  = 2'd3;
   localparam logic [1:0] SHAPE_SPARE = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [31:0] new_position;
   } tap_item_type;

   typedef struct packed {
      logic [31:0] position;
      logic [30:0] gain;
   } tap_beat_type;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_mode         = 1'b0;
   logic signed [31:0]    req_new_position = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic signed [31:0]    rsp_position;
   logic [30:0]           rsp_gain;
   logic                  csr_write        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_WINDOW_LOW;
   logic [31:0]           csr_data         = '0;

   echo_tap_position_envelope_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_new_position (req_new_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_gain         (rsp_gain),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Predictor state: mirrors the block's registers and tap state.
   cfg_type     cfg = '{window_low: RESET_WINDOW_LOW, window_high: RESET_WINDOW_HIGH,
                        fade_span: RESET_FADE_SPAN, tap_speed: RESET_TAP_SPEED,
                        write_step: RESET_WRITE_STEP, edge_mode: RESET_EDGE_MODE,
                        window_shape: RESET_WINDOW_SHAPE};
   logic [31:0] tap_pos = RESET_READ_POS;
   logic [1:0]  tap_dir = BOUNCE_NONE;

   tap_item_type tick_queue[$];      // beats waiting to be driven
   tap_beat_type expected_taps[$];   // predicted responses, oldest first
   tap_item_type next_item;
   tap_beat_type want;
   logic         req_taken = 1'b0;   // req beat accepted at the last rising edge
   int           idle_pct = 25;
   int           quiet_cycles = 0;
   int           mismatch_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one req beat to the tap state and returns the response it implies.
   // All sums are done in 64 bits; only the stored position wraps to 32.
   function automatic tap_beat_type next_tap(input logic mode, input logic [31:0] new_pos);
      longint       lo, hi, t, spd, ws, inc, nt, span, centre, half, offset, q, d, g;
      tap_beat_type beat;
      lo = longint'($signed(cfg.window_low));
      hi = longint'($signed(cfg.window_high));
      if (mode) begin
         tap_pos = new_pos;
         tap_dir = BOUNCE_NONE;
      end else begin
         t   = longint'($signed(tap_pos));
         spd = longint'($signed(cfg.tap_speed));
         ws  = longint'($signed(cfg.write_step));
         // a bounce forces the speed's sign; a stale code 3 uses it as set
         if (tap_dir == BOUNCE_DOWN)
            spd = (spd < 0) ? spd : -spd;
         else if (tap_dir == BOUNCE_UP)
            spd = (spd < 0) ? -spd : spd;
         inc = ws * SUBSAMPLES - spd;
         nt  = t + inc;
         if (nt <= hi && nt >= lo) begin
            t = nt;
         end else begin
            case (cfg.edge_mode)
               EDGE_CLAMP: t = (nt < lo) ? lo : hi;
               EDGE_REFLECT: begin
                  if (nt < lo) begin
                     tap_dir = BOUNCE_DOWN;
                     t = lo;
                  end else begin
                     tap_dir = BOUNCE_UP;
                     t = hi;
                  end
               end
               default: begin
                  span = hi - lo - longint'(cfg.fade_span);
                  if (span < 0)
                     span = -span;
                  if (nt > hi)
                     t -= span;
                  else if (nt < lo)
                     t += span;
                  if (t <= hi && t >= lo)
                     t += inc;
               end
            endcase
         end
         tap_pos = t[31:0];
      end

      t      = longint'($signed(tap_pos));
      centre = (lo + hi + 1) >>> 1;
      half   = (hi - lo + 1) >>> 1;
      offset = t - centre;
      if (offset < 0)
         offset = -offset;
      if (!(cfg.window_shape == SHAPE_LINEAR || cfg.window_shape == SHAPE_SQUARED) ||
          half <= 0) begin
         g = UNITY_GAIN;
      end else begin
         q = UNITY_GAIN / half;
         // offset*q above unity is exactly offset above floor(unity/q)
         if (q != 0 && offset > UNITY_GAIN / q) begin
            g = 0;
         end else begin
            d = offset * q;
            if (cfg.window_shape == SHAPE_LINEAR)
               g = UNITY_GAIN - d;
            else
               g = UNITY_GAIN - ((d * d) >>> 31);
         end
      end
      if (g < 0)
         g = 0;
      beat.position = tap_pos;
      beat.gain     = g[30:0];
      return beat;
   endfunction

   // Driver: a new beat goes out only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            next_item = tick_queue.pop_front();
            req_valid        <= 1'b1;
            req_mode         <= next_item.mode;
            req_new_position <= next_item.new_position;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // Monitor: predicts on each req beat, checks each rsp beat, runs the watchdog.
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_taps.size() == 0) begin
               $error("rsp beat with nothing outstanding: position %0d gain %0d",
                      rsp_position, rsp_gain);
               mismatch_count++;
            end else begin
               want = expected_taps.pop_front();
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", $signed(want.position),
                         rsp_position);
                  mismatch_count++;
               end
               if (rsp_gain !== want.gain) begin
                  $error("gain: expected %0d, got %0d", want.gain, rsp_gain);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_taps.push_back(next_tap(req_mode, req_new_position));
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_echo_tap_position_envelope_top: errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Blocks until every queued beat is driven and every response is back.
   task automatic settle();
      while (tick_queue.size() != 0 || req_valid || expected_taps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   // Reprograms every register; only done with the block drained.
   task automatic load_window(input cfg_type c);
      settle();
      repeat (4) @(posedge clock);
      write_csr(CSR_WINDOW_LOW,   c.window_low);
      write_csr(CSR_WINDOW_HIGH,  c.window_high);
      write_csr(CSR_FADE_SPAN,    {1'b0, c.fade_span});
      write_csr(CSR_TAP_SPEED,    {14'd0, c.tap_speed});
      write_csr(CSR_WRITE_STEP,   {27'd0, c.write_step});
      write_csr(CSR_EDGE_MODE,    {30'd0, c.edge_mode});
      write_csr(CSR_WINDOW_SHAPE, {30'd0, c.window_shape});
      @(negedge clock);
      csr_write <= 1'b0;
      cfg = c;
   endtask

   function automatic cfg_type make_window(input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [30:0] fade, input int spd,
                                           input int ws, input logic [1:0] edge_sel,
                                           input logic [1:0] shape);
      cfg_type c;
      c.window_low   = lo;
      c.window_high  = hi;
      c.fade_span    = fade;
      c.tap_speed    = 18'(spd);
      c.write_step   = 5'(ws);
      c.edge_mode    = edge_sel;
      c.window_shape = shape;
      return c;
   endfunction

   // Mostly modest windows so the edges get hit; some full-range, inverted and
   // single-point windows.
   function automatic cfg_type random_window();
      cfg_type c;
      int      lo;
      case ($urandom_range(0, 9))
         0: begin
            c.window_low  = $urandom;
            c.window_high = $urandom;
         end
         1: begin
            c.window_low  = 32'h8000_0000;
            c.window_high = 32'h7FFF_FFFF;
         end
         2: begin
            lo = int'($urandom_range(0, 4000)) - 2000;
            c.window_low  = lo;
            c.window_high = lo;
         end
         default: begin
            lo = int'($urandom_range(0, 2000000)) - 1000000;
            c.window_low  = lo;
            c.window_high = lo + int'($urandom_range(1, 1 << $urandom_range(4, 20)));
         end
      endcase
      case ($urandom_range(0, 2))
         0:       c.fade_span = '0;
         1:       c.fade_span = 31'($urandom_range(0, 1 << 16));
         default: c.fade_span = 31'($urandom >> 1);
      endcase
      c.tap_speed    = 18'(int'($urandom_range(0, 131072)) - 65536);
      c.write_step   = 5'(int'($urandom_range(0, 16)) - 8);
      c.edge_mode    = 2'($urandom_range(0, 3));
      c.window_shape = 2'($urandom_range(0, 3));
      return c;
   endfunction

   // Load target: half the time inside the window, otherwise anywhere.
   function automatic logic [31:0] pick_position();
      longint lo, hi;
      lo = longint'($signed(cfg.window_low));
      hi = longint'($signed(cfg.window_high));
      if ($urandom_range(0, 1) == 0 || hi < lo || hi - lo > 64'hFFFF_FFFE)
         return $urandom;
      return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
   endfunction

   task automatic push_tick();
      tick_queue.push_back('{mode: 1'b0, new_position: $urandom});
   endtask

   task automatic push_load(input logic [31:0] pos);
      tick_queue.push_back('{mode: 1'b1, new_position: pos});
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero net step, then loads at both extremes wrapping back
      push_tick();
      push_tick();
      push_load(32'h7FFF_FFFF);
      push_tick();
      push_load(32'h8000_0000);
      push_tick();

      // one-shot clamp at the top, triangle gain
      load_window(make_window(32'd0, 32'd4096, 31'd0, -1000, 1, EDGE_CLAMP,
                              SHAPE_LINEAR));
      push_load(32'd0);
      repeat (4) push_tick();

      // bounce off both edges, then a load clears the forced direction
      load_window(make_window(-32'sd2000, 32'd2000, 31'd0, 1500, 0, EDGE_REFLECT,
                              SHAPE_SQUARED));
      repeat (6) push_tick();
      push_load(32'd0);
      push_tick();

      // spare edge and shape codes: wrap with a crossfade, flat gain
      load_window(make_window(32'd0, 32'd10000, 31'd2000, -3000, 0, EDGE_SPARE,
                              SHAPE_SPARE));
      repeat (4) push_tick();

      // inverted window: negative half-width gives full gain
      load_window(make_window(32'd1000, -32'sd1000, 31'd0, 0, 2, EDGE_CYCLE,
                              SHAPE_LINEAR));
      push_load(32'd0);
      repeat (2) push_tick();

      // single-point window: zero half-width
      load_window(make_window(32'd500, 32'd500, 31'd0, 65536, -8, EDGE_CLAMP,
                              SHAPE_LINEAR));
      push_tick();

      // full-range window, widest fade, fastest speed: wraps across the 32-bit range
      load_window(make_window(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, -65536, 8,
                              EDGE_CYCLE, SHAPE_SQUARED));
      push_load(32'h7FFF_F000);
      repeat (2) push_tick();

      // random phases, ~130 beats each, mostly advances with some loads
      for (int phase = 0; phase < 12; phase++) begin
         load_window(random_window());
         idle_pct = (phase == 4) ? 0 : 25;   // one phase runs flat out on both sides
         for (int part = 0; part < 2; part++) begin
            for (int n = 0; n < 65; n++) begin
               if ($urandom_range(0, 9) == 0)
                  push_load(pick_position());
               else
                  push_tick();
            end
            // sender holds mid-phase until the pipeline is empty
            if (phase == 6 && part == 0)
               settle();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_taps.size() != 0) begin
         $error("%0d responses never arrived", expected_taps.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("tb_echo_tap_position_envelope_top: clean");
      else
         $display("tb_echo_tap_position_envelope_top: errors");
      $finish;
   end

endmodule
